[rtl/swm_pkg.sv]
// Shared types and constants for the sliding-window median filter.
// No dependencies; every other file but swm_ram imports this package.
package swm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MEDIAN_W = 16;
  localparam int unsigned TOTAL_W  = 48;
  localparam int unsigned WIN_W    = 13;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_INC,
    UPD_DEC,
    UPD_CLR
  } upd_op_e;

  // Broadcast update to every level: value is the sample, or the clear address.
  typedef struct packed {
    upd_op_e             op;
    logic [SAMPLE_W-1:0] value;
  } upd_t;

  // Descent step handed from one level to the next.
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] node;
    logic [WIN_W-1:0]    rank;
  } srch_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INSERT,
    ST_INS_WAIT,
    ST_SEARCH,
    ST_EMIT,
    ST_REMOVE,
    ST_REM_WAIT
  } state_e;

endpackage

[rtl/swm_in_if.sv]
// Input channel: one sample per item.
// Depends on swm_pkg.
interface swm_in_if import swm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

[rtl/swm_out_if.sv]
// Result channel: median and running total of medians.
// Depends on swm_pkg.
interface swm_out_if import swm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MEDIAN_W-1:0] median;
  logic [TOTAL_W-1:0]  median_total;

  modport source (output valid, output median, output median_total, input ready);
  modport sink   (input valid, input median, input median_total, output ready);
endinterface

[rtl/swm_cfg_if.sv]
// Configuration write channel carrying the window size.
// Depends on swm_pkg.
interface swm_cfg_if import swm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

[rtl/swm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[rtl/swm_cell.sv]
// One level of the count tree: its counts in a RAM, read-modify-write
// updates and one descent step of the median search. Depends on swm_pkg, swm_ram.
module swm_cell import swm_pkg::*; #(
  parameter int unsigned LEVEL       = 1,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned CNT_W       = 13
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  upd_t  upd_i,
  input  srch_t srch_i,
  output srch_t srch_o
);
  localparam int unsigned DEPTH = 2 ** LEVEL;
  localparam int unsigned AW    = LEVEL;

  logic [AW-1:0]    upd_addr;
  logic [AW-1:0]    srch_addr;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [CNT_W-1:0] wdata;
  logic [CNT_W-1:0] rdata;
  logic             we;
  logic             go_right;

  upd_op_e             rmw_op_q;
  logic [AW-1:0]       rmw_addr_q;
  logic                pend_q;
  logic [SAMPLE_W-1:0] pend_node_q;
  logic [WIN_W-1:0]    pend_rank_q;
  logic                srch_valid_q;
  logic [SAMPLE_W-1:0] srch_node_q;
  logic [WIN_W-1:0]    srch_rank_q;

  assign upd_addr  = upd_i.value[SAMPLE_BITS-1 -: LEVEL];
  assign srch_addr = AW'({srch_i.node, 1'b0});
  assign raddr     = srch_i.valid ? srch_addr : upd_addr;

  always_comb begin
    we    = 1'b0;
    waddr = rmw_addr_q;
    wdata = rdata;
    if (upd_i.op == UPD_CLR) begin
      we    = 1'b1;
      waddr = upd_i.value[AW-1:0];
      wdata = '0;
    end else if (rmw_op_q == UPD_INC) begin
      we    = 1'b1;
      wdata = rdata + CNT_W'(1);
    end else if (rmw_op_q == UPD_DEC) begin
      we    = 1'b1;
      wdata = rdata - CNT_W'(1);
    end
  end

  swm_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // rdata holds the left child's count: go right when the rank lies beyond it
  assign go_right = 32'(pend_rank_q) > 32'(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmw_op_q     <= UPD_NONE;
      pend_q       <= 1'b0;
      srch_valid_q <= 1'b0;
    end else begin
      rmw_op_q     <= (upd_i.op == UPD_INC || upd_i.op == UPD_DEC) ? upd_i.op : UPD_NONE;
      pend_q       <= srch_i.valid;
      srch_valid_q <= pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rmw_addr_q  <= upd_addr;
    pend_node_q <= srch_i.node;
    pend_rank_q <= srch_i.rank;
    srch_node_q <= SAMPLE_W'({pend_node_q, go_right});
    srch_rank_q <= go_right ? WIN_W'(pend_rank_q - WIN_W'(rdata)) : pend_rank_q;
  end

  assign srch_o = {srch_valid_q, srch_node_q, srch_rank_q};
endmodule

[rtl/sliding_window_median.sv]
// Sliding-window median filter over a chain of count-tree level cells.
// Each accepted item is inserted; once the window is full its median is then searched down
// the 16 levels, emitted, and the oldest sample removed; before the window fills no result is given.
// A new item is taken only back in ST_IDLE, so none is accepted while one is in flight, and a
// result waiting in the output register holds ST_EMIT; the level RAM read sets the descent pace.
// Reset, and every window_size write, start a clearing pass over the tree; no item taken.
module sliding_window_median import swm_pkg::*; #(
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  swm_in_if.sink     in_i,
  swm_out_if.source  out_o,
  swm_cfg_if.sink    cfg_i
);
  localparam int unsigned CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned RING_AW = $clog2(WINDOW_DEPTH);

  state_e state_q, state_d;

  logic [WIN_W-1:0]       window_q;
  logic [CNT_W-1:0]       win_eff;
  logic [RING_AW-1:0]     ptr_q, ptr_d, ptr_use;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic                   full_q, full_d;
  logic [SAMPLE_BITS-1:0] clr_q;
  logic [SAMPLE_BITS-1:0] v_q;
  logic [SAMPLE_BITS-1:0] old_q;
  logic [SAMPLE_BITS-1:0] med_q;
  logic                   start_q;
  logic                   out_valid_q;
  logic [MEDIAN_W-1:0]    median_q;
  logic [TOTAL_W-1:0]     total_q;
  logic                   cfg_fire, in_fire, out_load;
  logic [SAMPLE_BITS-1:0] ring_rdata;
  logic                   ring_we;
  logic [RING_AW-1:0]     oldest;
  upd_t                   upd;
  srch_t                  chain [SAMPLE_BITS+1];

  // Effective window: zero means one, saturate at the ring depth
  always_comb begin
    if (window_q == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(window_q) > 32'(WINDOW_DEPTH)) begin
      win_eff = CNT_W'(WINDOW_DEPTH);
    end else begin
      win_eff = CNT_W'(window_q);
    end
  end

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && (state_q == ST_IDLE);

  // Ring slot for this item, and the slot of the oldest sample after it
  assign ptr_use = (32'(ptr_q) >= 32'(win_eff)) ? '0 : ptr_q;
  assign oldest  = (32'(ptr_use) + 32'd1 >= 32'(win_eff)) ? '0 : RING_AW'(ptr_use + 1'b1);

  always_comb begin
    fill_d = fill_q;
    if (32'(fill_q) < 32'(win_eff)) begin
      fill_d = fill_q + CNT_W'(1);
    end
  end
  assign full_d = (32'(fill_d) >= 32'(win_eff));
  assign ptr_d  = oldest;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:    if (&clr_q) state_d = ST_IDLE;
      ST_IDLE:     if (in_fire) state_d = ST_INSERT;
      ST_INSERT:   state_d = ST_INS_WAIT;
      ST_INS_WAIT: state_d = full_q ? ST_SEARCH : ST_IDLE;
      ST_SEARCH:   if (chain[SAMPLE_BITS].valid) state_d = ST_EMIT;
      ST_EMIT:     if (out_load) state_d = ST_REMOVE;
      ST_REMOVE:   state_d = ST_REM_WAIT;
      ST_REM_WAIT: state_d = ST_IDLE;
      default:     state_d = ST_CLEAR;
    endcase
    if (cfg_fire) begin
      state_d = ST_CLEAR;
    end
  end

  // Outputs of the sequencer: tree updates, ring write, result load
  always_comb begin
    upd.op    = UPD_NONE;
    upd.value = SAMPLE_W'(v_q);
    ring_we   = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        upd.op    = UPD_CLR;
        upd.value = SAMPLE_W'(clr_q);
      end
      ST_INSERT: begin
        upd.op  = UPD_INC;
        ring_we = 1'b1;
      end
      ST_EMIT: begin
        out_load = !out_valid_q || out_o.ready;
      end
      ST_REMOVE: begin
        upd.op    = UPD_DEC;
        upd.value = SAMPLE_W'(old_q);
      end
      default: begin
        upd.op = UPD_NONE;
      end
    endcase
  end

  swm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ptr_use),
    .wdata_i (v_q),
    .raddr_i (oldest),
    .rdata_o (ring_rdata)
  );

  // Search enters the chain at the root with the lower-median rank
  assign chain[0].valid = start_q;
  assign chain[0].node  = '0;
  assign chain[0].rank  = WIN_W'((32'(win_eff) + 32'd1) >> 1);

  for (genvar l = 1; l <= SAMPLE_BITS; l++) begin : g_level
    swm_cell #(.LEVEL(l), .SAMPLE_BITS(SAMPLE_BITS), .CNT_W(CNT_W)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .upd_i  (upd),
      .srch_i (chain[l-1]),
      .srch_o (chain[l])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      window_q    <= WIN_W'(1);
      ptr_q       <= '0;
      fill_q      <= '0;
      full_q      <= 1'b0;
      clr_q       <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q <= state_d;
      start_q <= (state_q == ST_INS_WAIT) && full_q;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == ST_INSERT) begin
        ptr_q  <= ptr_d;
        fill_q <= fill_d;
        full_q <= full_d;
      end
      // Drop the window on reconfiguration; keep the running total
      if (cfg_fire) begin
        window_q <= cfg_i.window_size;
        ptr_q    <= '0;
        fill_q   <= '0;
        clr_q    <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        total_q     <= total_q + TOTAL_W'(med_q);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      v_q <= in_i.sample[SAMPLE_BITS-1:0];
    end
    // A window of one removes the sample just added
    if (state_q == ST_INS_WAIT) begin
      old_q <= (win_eff == CNT_W'(1)) ? v_q : ring_rdata;
    end
    if (state_q == ST_SEARCH) begin
      med_q <= chain[SAMPLE_BITS].node[SAMPLE_BITS-1:0];
    end
    if (out_load) begin
      median_q <= MEDIAN_W'(med_q);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.median       = median_q;
  assign out_o.median_total = total_q;
endmodule
